// File: hdl/assert_macros.svh
// Assertion macros shared by the tilt angle RTL; they sample on clk and hold off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Condition and consequence in the same cycle.
`define AT_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
// Consequence in the cycle after the condition.
`define AT_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define AT_ASSERT_NOW(lbl, cond, prop)
`define AT_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

// File: hdl/atilt_pkg.sv
// Types, constants and step functions for the tilt angle pipeline.
package atilt_pkg;

  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_STEPS = 31;
  localparam int MAG_W        = 30;
  localparam int VEC_W        = 34;
  localparam logic [30:0] QUARTER_TURN = 31'h4000_0000;

  // Sideband that travels with each angle lane.
  typedef struct packed {
    logic zero_num;
    logic zero_den;
    logic neg;
  } atilt_flags_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] res;
  } sqrt_st_t;

  // atan(2^-i), 2^32 units per full turn
  localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001
  };

  // One digit of the restoring integer square root.
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, int idx);
    logic [63:0] bitv;
    logic [63:0] sum;
    sqrt_st_t    o;
    bitv = 64'd1 << (62 - 2 * idx);
    sum  = s.res + bitv;
    if (s.v >= sum) begin
      o.v   = s.v - sum;
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.v   = s.v;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

endpackage

// File: hdl/atilt_norm.sv
// Squared-magnitude sums, zero flags and power-of-four normalization for one lane.
module atilt_norm (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [30:0]            num_a,
  input  logic [30:0]            num_b,
  input  logic [30:0]            den_a,
  input  logic [30:0]            den_b,
  input  logic                   neg_in,
  output logic                   out_valid,
  output logic [59:0]            nsq_norm,
  output logic [59:0]            dsq_norm,
  output atilt_pkg::atilt_flags_t flags_out
);
  import atilt_pkg::*;

  logic [31:0]  nsq, dsq, nsq_b, dsq_b;
  logic         va, vb;
  atilt_flags_t fa, fb;
  logic [31:0]  mx;
  logic [4:0]   pos;
  logic [4:0]   k;
  logic [4:0]   k_next;

  // stage a: sums and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      nsq         <= 32'(num_a) + 32'(num_b);
      dsq         <= 32'(den_a) + 32'(den_b);
      fa.neg      <= neg_in;
      fa.zero_num <= (num_a == '0) && (num_b == '0);
      fa.zero_den <= (den_a == '0) && (den_b == '0);
    end
  end

  // leading one of the larger square, then shift count so it lands at bit 58 or 59
  always_comb begin
    mx  = (nsq > dsq) ? nsq : dsq;
    pos = '0;
    for (int b = 0; b < 32; b++) begin
      if (mx[b]) pos = 5'(b);
    end
    k_next = 5'((7'd59 - 7'(pos)) >> 1);
  end

  // stage b: shift count
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
    if (en) begin
      nsq_b <= nsq;
      dsq_b <= dsq;
      fb    <= fa;
      k     <= k_next;
    end
  end

  // stage c: shifted squares
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vb;
    end
    if (en) begin
      nsq_norm  <= 60'(nsq_b) << {k, 1'b0};
      dsq_norm  <= 60'(dsq_b) << {k, 1'b0};
      flags_out <= fb;
    end
  end

endmodule

// File: hdl/atilt_isqrt.sv
// Pipelined square roots of a numerator and a denominator, one result bit per stage.
module atilt_isqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [59:0]            nsq,
  input  logic [59:0]            dsq,
  input  atilt_pkg::atilt_flags_t flags_in,
  output logic                   out_valid,
  output logic [29:0]            num_root,
  output logic [29:0]            den_root,
  output atilt_pkg::atilt_flags_t flags_out
);
  import atilt_pkg::*;

  sqrt_st_t     sn [0:SQRT_STEPS];
  sqrt_st_t     sd [0:SQRT_STEPS];
  logic         vld [0:SQRT_STEPS];
  atilt_flags_t fl [0:SQRT_STEPS];

  assign sn[0].v   = 64'(nsq);
  assign sn[0].res = '0;
  assign sd[0].v   = 64'(dsq);
  assign sd[0].res = '0;
  assign vld[0]    = in_valid;
  assign fl[0]     = flags_in;

  // one stage per root digit
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        sn[i+1] <= sqrt_step(sn[i], i);
        sd[i+1] <= sqrt_step(sd[i], i);
        fl[i+1] <= fl[i];
      end
    end
  end

  assign out_valid = vld[SQRT_STEPS];
  assign num_root  = sn[SQRT_STEPS].res[29:0];
  assign den_root  = sd[SQRT_STEPS].res[29:0];
  assign flags_out = fl[SQRT_STEPS];

endmodule

// File: hdl/atilt_cordic.sv
// Vectoring CORDIC, one micro-rotation per stage, then conversion to signed degrees.
module atilt_cordic #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [29:0]            num_root,
  input  logic [29:0]            den_root,
  input  atilt_pkg::atilt_flags_t flags_in,
  output logic                   out_valid,
  output logic [15:0]            angle
);
  import atilt_pkg::*;

  logic signed [VEC_W-1:0] vx [0:CORDIC_STEPS];
  logic signed [VEC_W-1:0] vy [0:CORDIC_STEPS];
  logic signed [VEC_W-1:0] az [0:CORDIC_STEPS];
  logic                    vld [0:CORDIC_STEPS];
  atilt_flags_t            fl [0:CORDIC_STEPS];

  assign vx[0]  = VEC_W'(den_root);
  assign vy[0]  = VEC_W'(num_root);
  assign az[0]  = '0;
  assign vld[0] = in_valid;
  assign fl[0]  = flags_in;

  // micro-rotations toward the x axis
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic signed [VEC_W-1:0] STEP_ANG = VEC_W'(ATAN_TAB[i]);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        fl[i+1] <= fl[i];
        if (vy[i] > 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          az[i+1] <= az[i] + STEP_ANG;
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          az[i+1] <= az[i] - STEP_ANG;
        end
      end
    end
  end

  logic signed [VEC_W-1:0] zf;
  logic [30:0]             tsel;
  logic [38:0]             u;
  logic                    vu;
  atilt_flags_t            fu;
  logic [55:0]             dwide;
  logic [23:0]             dsh;
  logic [15:0]             mag;

  // clamp to the first quadrant; a zero divisor is a quarter turn
  always_comb begin
    zf = az[CORDIC_STEPS];
    if (fl[CORDIC_STEPS].zero_den) begin
      tsel = QUARTER_TURN;
    end else if (zf < 0) begin
      tsel = '0;
    end else if (zf > VEC_W'(QUARTER_TURN)) begin
      tsel = QUARTER_TURN;
    end else begin
      tsel = zf[30:0];
    end
  end

  // degree scale stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vu <= 1'b0;
    end else if (en) begin
      vu <= vld[CORDIC_STEPS];
    end
    if (en) begin
      u  <= 39'(tsel) * 39'd360;
      fu <= fl[CORDIC_STEPS];
    end
  end

  // round half up, saturate, zero for a zero numerator; the sign follows in the output register
  always_comb begin
    dwide = (56'(u) << ANGLE_FRAC_BITS) + (56'd1 << 31);
    dsh   = dwide[55:32];
    mag   = (dsh > 24'd32767) ? 16'd32767 : dsh[15:0];
    if (fu.zero_num) begin
      mag = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vu;
    end
    if (en) begin
      angle <= fu.neg ? (16'd0 - mag) : mag;
    end
  end

endmodule

// File: hdl/accel_tilt_angles.sv
// Top level: three tilt angles from one accelerometer sample, fully pipelined.
//
// Channel   Direction  Payload (low bit first)
// s_axis    in         tdata[47:0] = accel_x, accel_y, accel_z
// m_axis    out        tdata[47:0] = pitch_deg, roll_deg, incline_deg
//
// One item per cycle unless the output stalls; pipeline stages:
// 1 square, 3 normalize, 32 square-root digit, 31 CORDIC, 2 degree stages, 1 output.
// rst is synchronous and clears every valid bit; payload registers are not reset.
// Stalls: the pipeline holds only when the output register is waiting and the
// last stage is full; otherwise new items keep entering behind a waiting result.
module accel_tilt_angles #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // pitch_deg, roll_deg, incline_deg
);
  import atilt_pkg::*;
`include "assert_macros.svh"

  logic              en;
  logic              v1;
  logic [30:0]       xx, yy, zz;
  logic              nx, ny, nz;
  logic signed [15:0] ax, ay, az;

  logic [2:0]         nv, sv, lv;
  logic [59:0]        nn [0:2];
  logic [59:0]        nd [0:2];
  atilt_flags_t       nf [0:2];
  atilt_flags_t       sf [0:2];
  logic [29:0]        rn [0:2];
  logic [29:0]        rd [0:2];
  logic [15:0]        ang [0:2];
  logic [30:0]        na [0:2];
  logic [30:0]        nb [0:2];
  logic [30:0]        da [0:2];
  logic [30:0]        db [0:2];
  logic [2:0]         neg;

  assign ax = s_axis_tdata[15:0];
  assign ay = s_axis_tdata[31:16];
  assign az = s_axis_tdata[47:32];

  // global advance: stop only when a full last stage cannot move out
  assign en            = !lv[0] || !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
    if (en) begin
      xx <= 31'(ax * ax);
      yy <= 31'(ay * ay);
      zz <= 31'(az * az);
      nx <= ax[15];
      ny <= ay[15];
      nz <= az[15];
    end
  end

  // lane operands: pitch, roll, incline
  always_comb begin
    na[0] = xx; nb[0] = '0; da[0] = yy; db[0] = zz; neg[0] = nx;
    na[1] = yy; nb[1] = '0; da[1] = xx; db[1] = zz; neg[1] = ny;
    na[2] = xx; nb[2] = yy; da[2] = zz; db[2] = '0; neg[2] = nz;
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    atilt_norm u_norm (
      .clk, .rst, .en,
      .in_valid (v1),
      .num_a    (na[l]),
      .num_b    (nb[l]),
      .den_a    (da[l]),
      .den_b    (db[l]),
      .neg_in   (neg[l]),
      .out_valid(nv[l]),
      .nsq_norm (nn[l]),
      .dsq_norm (nd[l]),
      .flags_out(nf[l])
    );
    atilt_isqrt u_isqrt (
      .clk, .rst, .en,
      .in_valid (nv[l]),
      .nsq      (nn[l]),
      .dsq      (nd[l]),
      .flags_in (nf[l]),
      .out_valid(sv[l]),
      .num_root (rn[l]),
      .den_root (rd[l]),
      .flags_out(sf[l])
    );
    atilt_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic (
      .clk, .rst, .en,
      .in_valid (sv[l]),
      .num_root (rn[l]),
      .den_root (rd[l]),
      .flags_in (sf[l]),
      .out_valid(lv[l]),
      .angle    (ang[l])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= lv[0];
    end
    if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tdata <= {ang[2], ang[1], ang[0]};
    end
  end

  // the three lanes move in lock step
  `AT_ASSERT_NOW(a_lane_sync, 1'b1, (lv[0] == lv[1]) && (lv[1] == lv[2]))
  // a waiting result with a full last stage blocks the input
  `AT_ASSERT_NOW(a_full_stall, m_axis_tvalid && !m_axis_tready && lv[0], !s_axis_tready)
  // a new result only comes from a full last stage
  `AT_ASSERT_NOW(a_out_source, $rose(m_axis_tvalid), $past(lv[0]))
  // saturation keeps every angle off the most negative code; this check covers pitch and incline
  `AT_ASSERT_NOW(a_no_min, m_axis_tvalid,
                 (m_axis_tdata[15:0] != 16'h8000) && (m_axis_tdata[47:32] != 16'h8000))

endmodule
